>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/tmva_pkg.sv
// ---------------------------------------------------------------------------
// tmva_pkg
// Widths, weight codes and stage records of the ternary row accumulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmva_pkg;

   localparam int LANES      = 4;
   localparam int SUM_WIDTH  = 32;
   localparam int ACT_W      = 16;
   localparam int CODE_W     = 2;
   localparam int WBYTE_W    = LANES * CODE_W;
   localparam int NVALID_W   = 3;
   localparam int SCALE_W    = 16;
   localparam int TERM_W     = ACT_W + 2;
   localparam int PART_W     = TERM_W + $clog2(LANES);
   localparam int FRAC_BITS  = 8;
   localparam int RES_W      = 48;
   localparam int PROD_W     = SUM_WIDTH + SCALE_W;
   localparam int REQ_BITS   = WBYTE_W + LANES * ACT_W + NVALID_W + SCALE_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RES_W + 7) / 8) * 8;

   localparam logic [CODE_W-1:0] CODE_MASK = 2'h3;

   // Weight is code minus one.
   localparam logic [CODE_W-1:0] CODE_NEG  = 2'd0;
   localparam logic [CODE_W-1:0] CODE_ZERO = 2'd1;
   localparam logic [CODE_W-1:0] CODE_POS  = 2'd2;
   localparam logic [CODE_W-1:0] CODE_DBL  = 2'd3;

   typedef logic signed [TERM_W-1:0] term_type;

   typedef struct packed {
      logic valid;
      logic eor;
   } stage_ctl_type;

   typedef struct packed {
      logic                        valid;
      logic signed [SUM_WIDTH-1:0] sum;
      logic                        sat;
      logic signed [SCALE_W-1:0]   scale;
   } row_out_type;

   typedef struct packed {
      logic                    valid;
      logic signed [RES_W-1:0] result;
      logic                    sat;
   } result_type;

endpackage

>>> hw/rtl/ternary_matvec_accumulate.sv
// ---------------------------------------------------------------------------
// ternary_matvec_accumulate
// Ternary-weight row accumulator with per-row scaling and saturation.
// ---------------------------------------------------------------------------
// Input beats on the req_ channel carry one packed weight byte (four 2-bit
// codes, weight = code - 1), four Q8.8 activations, the number of leading
// lanes that count, and the row scale; req_tlast marks the last beat of a
// row. Four lanes weight the activations side by side, a merge stage adds
// the terms, and a saturating accumulator keeps the running row sum.
// On the beat with req_tlast set, the row sum including that beat is
// multiplied by the scale, shifted right by eight (floor) and clamped to
// 48 bits; one rsp_ beat then carries the result, with rsp_tuser set if the
// sum or the result saturated. Beats without req_tlast give no rsp_ beat.
// Throughput: one req_ beat per cycle while req_tready is high. The edge
// that accepts a last beat loads the lane registers; the merge, accumulate,
// multiply and output registers follow in order; rsp_tvalid is registered.
// Reset clears the row sum, the saturation flag and all valid bits.
// When the receiver stalls, a skid register catches one more result; once
// it is full, req_tready drops and the whole pipeline holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ternary_matvec_accumulate
   import tmva_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // weight_byte, act_lane0, act_lane1, act_lane2, act_lane3, lanes_valid,
   // row_scale, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,  // end_of_row
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // row_result
   output logic                  rsp_tuser   // sum_saturated
);

   localparam int ACT_LSB    = WBYTE_W;
   localparam int NVALID_LSB = ACT_LSB + LANES * ACT_W;
   localparam int SCALE_LSB  = NVALID_LSB + NVALID_W;

   logic                      pipe_en;
   logic                      req_beat;
   logic [WBYTE_W-1:0]        weight_byte;
   logic [NVALID_W-1:0]       lanes_valid;
   stage_ctl_type             lane_ctl_ff;
   logic signed [SCALE_W-1:0] lane_scale_ff;
   term_type                  terms [LANES];
   row_out_type               row_done;
   result_type                result;

   logic                      out_valid_ff;
   logic signed [RES_W-1:0]   out_result_ff;
   logic                      out_sat_ff;
   logic                      skid_valid_ff;
   logic signed [RES_W-1:0]   skid_result_ff;
   logic                      skid_sat_ff;
   logic                      new_result;

   assign pipe_en     = !skid_valid_ff;
   assign req_tready  = pipe_en;
   assign req_beat    = req_tvalid && req_tready;
   assign weight_byte = req_tdata[WBYTE_W-1:0];
   assign lanes_valid = req_tdata[NVALID_LSB +: NVALID_W];

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      tmva_lane u_lane (
         .clock   (clock),
         .pipe_en (pipe_en),
         .code    (weight_byte[CODE_W*k +: CODE_W]),
         .act     (req_tdata[ACT_LSB + ACT_W*k +: ACT_W]),
         .lane_on (lanes_valid > NVALID_W'(k)),
         .term_ff (terms[k])
      );
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lane_scale_ff <= req_tdata[SCALE_LSB +: SCALE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ctl_ff <= '0;
      end else if (pipe_en) begin
         lane_ctl_ff.valid <= req_beat;
         lane_ctl_ff.eor   <= req_tlast;
      end
   end

   tmva_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .pipe_en    (pipe_en),
      .lane_ctl   (lane_ctl_ff),
      .lane_scale (lane_scale_ff),
      .terms      (terms),
      .row_ff     (row_done)
   );

   tmva_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .pipe_en (pipe_en),
      .row_in  (row_done),
      .result  (result)
   );

   assign new_result = result.valid && pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready || !out_valid_ff) begin
            if (skid_valid_ff) begin
               out_valid_ff   <= 1'b1;
               out_result_ff  <= skid_result_ff;
               out_sat_ff     <= skid_sat_ff;
               skid_valid_ff  <= 1'b0;
            end else begin
               out_valid_ff   <= new_result;
               out_result_ff  <= result.result;
               out_sat_ff     <= result.sat;
            end
         end else if (new_result) begin
            skid_valid_ff  <= 1'b1;
            skid_result_ff <= result.result;
            skid_sat_ff    <= result.sat;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_result_ff);
   assign rsp_tuser  = out_sat_ff;

   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && rsp_tready, !skid_valid_ff)

endmodule

>>> hw/rtl/tmva_lane.sv
// ---------------------------------------------------------------------------
// tmva_lane
// One weight lane: turns a 2-bit code and an activation into a registered
// weighted term (-act, 0, +act or +2*act).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmva_lane
   import tmva_pkg::*;
(
   input  logic                    clock,
   input  logic                    pipe_en,
   input  logic [CODE_W-1:0]       code,
   input  logic signed [ACT_W-1:0] act,
   input  logic                    lane_on,
   output term_type                term_ff
);

   term_type act_ext;
   term_type term_in;

   assign act_ext = TERM_W'(act);

   always_comb begin
      unique case (code & CODE_MASK)
         CODE_NEG:  term_in = -act_ext;
         CODE_ZERO: term_in = '0;
         CODE_POS:  term_in = act_ext;
         CODE_DBL:  term_in = act_ext <<< 1;
         default:   term_in = '0;
      endcase
      if (!lane_on) begin
         term_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         term_ff <= term_in;
      end
   end

endmodule

>>> hw/rtl/tmva_accum.sv
// ---------------------------------------------------------------------------
// tmva_accum
// Merges the lane terms into one partial sum, then adds it to the running
// row sum with saturation and hands the finished row on at end of row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmva_accum
   import tmva_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pipe_en,
   input  stage_ctl_type             lane_ctl,
   input  logic signed [SCALE_W-1:0] lane_scale,
   input  term_type                  terms [LANES],
   output row_out_type               row_ff
);

   logic signed [PART_W-1:0]    part_in;
   logic signed [PART_W-1:0]    part_ff;
   stage_ctl_type               merge_ctl_ff;
   logic signed [SCALE_W-1:0]   merge_scale_ff;

   logic signed [SUM_WIDTH-1:0] row_sum_ff;
   logic signed [SUM_WIDTH-1:0] row_sum_in;
   logic                        row_ovf_ff;
   logic                        row_ovf_in;
   logic signed [SUM_WIDTH:0]   wide_sum;
   logic signed [SUM_WIDTH-1:0] clamped;
   logic                        clamp_hit;
   row_out_type                 row_in;

   always_comb begin
      part_in = '0;
      for (int k = 0; k < LANES; k++) begin
         part_in = part_in + PART_W'(terms[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         part_ff        <= part_in;
         merge_scale_ff <= lane_scale;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_ctl_ff <= '0;
      end else if (pipe_en) begin
         merge_ctl_ff <= lane_ctl;
      end
   end

   // Saturating accumulate: one spare top bit shows an overflow.
   assign wide_sum = (SUM_WIDTH + 1)'(row_sum_ff) + (SUM_WIDTH + 1)'(part_ff);

   always_comb begin
      clamp_hit = wide_sum[SUM_WIDTH] != wide_sum[SUM_WIDTH-1];
      if (!clamp_hit) begin
         clamped = wide_sum[SUM_WIDTH-1:0];
      end else if (wide_sum[SUM_WIDTH]) begin
         clamped = {1'b1, {(SUM_WIDTH - 1){1'b0}}};
      end else begin
         clamped = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
      end
   end

   always_comb begin
      row_sum_in   = row_sum_ff;
      row_ovf_in   = row_ovf_ff;
      row_in       = row_ff;
      row_in.valid = 1'b0;
      if (merge_ctl_ff.valid) begin
         row_sum_in = clamped;
         row_ovf_in = row_ovf_ff | clamp_hit;
         if (merge_ctl_ff.eor) begin
            row_in.valid = 1'b1;
            row_in.sum   = clamped;
            row_in.sat   = row_ovf_ff | clamp_hit;
            row_in.scale = merge_scale_ff;
            row_sum_in   = '0;
            row_ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff <= '0;
         row_ovf_ff <= 1'b0;
         row_ff     <= '0;
      end else if (pipe_en) begin
         row_sum_ff <= row_sum_in;
         row_ovf_ff <= row_ovf_in;
         row_ff     <= row_in;
      end
   end

endmodule

>>> hw/rtl/tmva_scale.sv
// ---------------------------------------------------------------------------
// tmva_scale
// Multiplies a finished row sum by its scale, then drops the eight
// fraction bits (floor) and clamps to the result range.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmva_scale
   import tmva_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pipe_en,
   input  row_out_type row_in,
   output result_type  result
);

   localparam int SH_W  = PROD_W - FRAC_BITS;
   localparam int EXT_W = SH_W + RES_W;
   localparam logic signed [EXT_W-1:0] RES_MAX_EXT =
      {{(EXT_W - RES_W + 1){1'b0}}, {(RES_W - 1){1'b1}}};
   localparam logic signed [EXT_W-1:0] RES_MIN_EXT =
      {{(EXT_W - RES_W + 1){1'b1}}, {(RES_W - 1){1'b0}}};

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     sat_ff;
   logic                     valid_ff;
   logic signed [EXT_W-1:0]  shifted;

   assign prod_in = row_in.sum * row_in.scale;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         prod_ff <= prod_in;
         sat_ff  <= row_in.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pipe_en) begin
         valid_ff <= row_in.valid;
      end
   end

   // Dropping the low bits of a two's complement value rounds toward minus infinity.
   assign shifted = EXT_W'($signed(prod_ff[PROD_W-1:FRAC_BITS]));

   always_comb begin
      result.valid = valid_ff;
      result.sat   = sat_ff;
      if (shifted > RES_MAX_EXT) begin
         result.result = RES_MAX_EXT[RES_W-1:0];
         result.sat    = 1'b1;
      end else if (shifted < RES_MIN_EXT) begin
         result.result = RES_MIN_EXT[RES_W-1:0];
         result.sat    = 1'b1;
      end else begin
         result.result = shifted[RES_W-1:0];
      end
   end

endmodule
